>>> sv/lens_ball_remap_coordinate_core_defines.svh
// Assertion macros shared by the lens-ball coordinate core
`ifndef LENS_BALL_REMAP_COORDINATE_CORE_DEFINES_SVH
`define LENS_BALL_REMAP_COORDINATE_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
// property must hold at every edge out of reset
`define LBRC_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("lbrc assertion failed");
// antecedent implies consequent in the same cycle
`define LBRC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lbrc implication failed");
`else
`define LBRC_ASSERT(lbl, clk, rst_n, prop)
`define LBRC_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`endif
`endif

>>> sv/lbrc_pkg.sv
package lbrc_pkg;

    // register indexes
    localparam logic CFG_RADIUS = 1'b0;
    localparam logic CFG_BULGE  = 1'b1;

    localparam logic [6:0] RADIUS_RST = 7'd16;
    localparam logic [6:0] BULGE_RST  = 7'd8;

    // pipeline layout
    localparam int SQ_STEPS = 7;                 // result bits of a 14-bit square root
    localparam int ST_S0    = 1;                 // first root step for s and z
    localparam int ST_D     = ST_S0 + SQ_STEPS;  // row half-span radicand
    localparam int ST_DX0   = ST_D + 1;          // root steps for dx, divide steps
    localparam int ST_FIN   = ST_DX0 + SQ_STEPS; // offsets, row multiply
    localparam int NST      = ST_FIN + 2;        // last stage is the output register

    // square root state: remaining radicand and partial root
    typedef struct packed {
        logic [13:0] n;
        logic [14:0] res;
    } t_sq;

    // divider state: partial remainder and dividend/quotient shift word
    typedef struct packed {
        logic [7:0]  rem;
        logic [13:0] dq;
    } t_dv;

    typedef struct packed {
        logic [6:0]  r;
        logic [6:0]  m;
        logic [7:0]  i;
        logic [7:0]  x;
        logic        err;
        logic [14:0] i2;
        t_sq         s;
        t_sq         z;
        t_sq         d;
        logic        dpos;
        logic [6:0]  zv;
        logic        negi;
        logic        negx;
        t_dv         qi;
        t_dv         qx;
        logic        in_lens;
        logic [15:0] prod;
        logic [15:0] col;
        logic [7:0]  width;
        logic [6:0]  start;
        logic [15:0] index;
    } t_pl;

    // one step of the bit-pair floor square root
    function automatic t_sq sq_step(t_sq a, int k);
        logic [14:0] bitv;
        logic [14:0] sum;
        t_sq         o;
        bitv = 15'(1) << (12 - 2 * k);
        sum  = a.res + bitv;
        if ({1'b0, a.n} >= sum) begin
            o.n   = a.n - sum[13:0];
            o.res = (a.res >> 1) + bitv;
        end else begin
            o.n   = a.n;
            o.res = a.res >> 1;
        end
        return o;
    endfunction

    // one restoring divide step, one quotient bit
    function automatic t_dv dv_step(t_dv a, logic [6:0] z);
        logic [7:0] rsh;
        logic       ge;
        t_dv        o;
        rsh   = {a.rem[6:0], a.dq[13]};
        ge    = rsh >= {1'b0, z};
        o.dq  = {a.dq[12:0], ge};
        o.rem = ge ? rsh - {1'b0, z} : rsh;
        return o;
    endfunction

endpackage

>>> sv/lens_ball_remap_coordinate_core.sv
// Lens-ball coordinate core: one pixel offset in, one remap result out.
// Throughput: one beat per cycle; the pipeline stalls as a whole only while
// the output register holds a beat that is not taken.
// Reset (synchronous, active low) empties the pipeline and sets radius 16, bulge 8.
`include "lens_ball_remap_coordinate_core_defines.svh"
module lens_ball_remap_coordinate_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic signed [7:0] i_row_offset,
    input  logic signed [7:0] i_col_offset,
    output logic              o_valid,
    input  logic              i_ready,
    output logic              o_inside_res,
    output logic [15:0]       o_source_index,
    output logic [7:0]        o_span_width,
    output logic [6:0]        o_span_start,
    output logic              o_config_error,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic              i_cfg_index,
    input  logic [6:0]        i_cfg_data
);
    import lbrc_pkg::*;

    logic [6:0] r_radius;
    logic [6:0] r_bulge;
    logic [NST-1:0] r_vld;
    t_pl r_pl [NST];
    t_pl n_pl [NST];
    logic adv;

    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= RADIUS_RST;
            r_bulge  <= BULGE_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_RADIUS: r_radius <= i_cfg_data;
                CFG_BULGE:  r_bulge  <= i_cfg_data;
                default:    r_radius <= r_radius;
            endcase
        end
    end

    // whole pipeline moves unless the output beat is stalled
    assign adv     = !r_vld[NST-1] || i_ready;
    assign o_ready = adv;

    always_comb begin
        logic [7:0]         ai;
        logic [7:0]         ax;
        logic [13:0]        r2;
        logic [13:0]        m2;
        logic [15:0]        x2;
        logic signed [15:0] sa;
        logic signed [16:0] sz;
        logic signed [16:0] dd;
        logic [13:0]        ss;
        logic [6:0]         dx;
        logic [13:0]        qmag;
        logic [15:0]        yq;
        logic [15:0]        xq;
        logic [15:0]        yy;
        logic signed [8:0]  xs;
        logic signed [8:0]  dxs;
        logic [31:0]        pw;

        // entry: squares and the two radicands
        n_pl[0]       = r_pl[0];
        ai            = i_row_offset[7] ? 8'(-i_row_offset) : i_row_offset;
        ax            = i_col_offset[7] ? 8'(-i_col_offset) : i_col_offset;
        r2            = r_radius * r_radius;
        m2            = r_bulge * r_bulge;
        n_pl[0].i2    = 15'(ai * ai);
        x2            = ai * ai + ax * ax;
        sa            = $signed({2'b0, r2}) - $signed({2'b0, m2});
        sz            = $signed({3'b0, r2}) - $signed({1'b0, x2});
        n_pl[0].r     = r_radius;
        n_pl[0].m     = r_bulge;
        n_pl[0].i     = i_row_offset;
        n_pl[0].x     = i_col_offset;
        n_pl[0].err   = r_bulge >= r_radius;
        n_pl[0].s.n   = (sa > 0) ? sa[13:0] : '0;
        n_pl[0].s.res = '0;
        n_pl[0].z.n   = (sz > 0) ? sz[13:0] : '0;
        n_pl[0].z.res = '0;

        for (int k = 1; k < NST; k++) begin
            n_pl[k] = r_pl[k-1];
            if (k >= ST_S0 && k < ST_D) begin
                // roots of r*r - m*m and r*r - x*x - i*i
                n_pl[k].s = sq_step(r_pl[k-1].s, k - ST_S0);
                n_pl[k].z = sq_step(r_pl[k-1].z, k - ST_S0);
            end else if (k == ST_D) begin
                // half-span radicand and the two quotient numerators
                ss = 14'(r_pl[k-1].s.res[6:0] * r_pl[k-1].s.res[6:0]);
                dd = $signed({3'b0, ss}) - $signed({2'b0, r_pl[k-1].i2});
                n_pl[k].dpos  = dd > 0;
                n_pl[k].d.n   = (dd > 0) ? dd[13:0] : '0;
                n_pl[k].d.res = '0;
                n_pl[k].zv    = r_pl[k-1].z.res[6:0];
                ai = r_pl[k-1].i[7] ? 8'(-r_pl[k-1].i) : r_pl[k-1].i;
                ax = r_pl[k-1].x[7] ? 8'(-r_pl[k-1].x) : r_pl[k-1].x;
                n_pl[k].negi   = r_pl[k-1].i[7];
                n_pl[k].negx   = r_pl[k-1].x[7];
                n_pl[k].qi.rem = '0;
                n_pl[k].qi.dq  = 14'(ai * r_pl[k-1].m);
                n_pl[k].qx.rem = '0;
                n_pl[k].qx.dq  = 14'(ax * r_pl[k-1].m);
            end else if (k >= ST_DX0 && k < ST_FIN) begin
                // dx root step, two quotient bits per stage
                n_pl[k].d  = sq_step(r_pl[k-1].d, k - ST_DX0);
                n_pl[k].qi = dv_step(dv_step(r_pl[k-1].qi, r_pl[k-1].zv), r_pl[k-1].zv);
                n_pl[k].qx = dv_step(dv_step(r_pl[k-1].qx, r_pl[k-1].zv), r_pl[k-1].zv);
            end else if (k == ST_FIN) begin
                // span, inside test, source row times diameter
                dx  = r_pl[k-1].d.res[6:0];
                xs  = {r_pl[k-1].x[7], r_pl[k-1].x};
                dxs = {2'b0, dx};
                n_pl[k].in_lens = (dx != '0) && (xs > -dxs) && (xs <= dxs);
                n_pl[k].width   = r_pl[k-1].dpos ? {dx, 1'b0} : '0;
                n_pl[k].start   = r_pl[k-1].dpos ? r_pl[k-1].r - dx : '0;
                qmag = (r_pl[k-1].zv == '0) ? '0 : r_pl[k-1].qi.dq;
                yq   = r_pl[k-1].negi ? 16'(-{2'b0, qmag}) : {2'b0, qmag};
                qmag = (r_pl[k-1].zv == '0) ? '0 : r_pl[k-1].qx.dq;
                xq   = r_pl[k-1].negx ? 16'(-{2'b0, qmag}) : {2'b0, qmag};
                yy   = yq + {9'b0, r_pl[k-1].r};
                pw   = yy * {8'b0, r_pl[k-1].r, 1'b0};
                n_pl[k].prod = pw[15:0];
                n_pl[k].col  = xq + {9'b0, r_pl[k-1].r};
            end else begin
                // final index
                n_pl[k].index = r_pl[k-1].in_lens ? r_pl[k-1].prod + r_pl[k-1].col : '0;
            end
        end
    end

    // pipeline registers with travelling valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[NST-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int k = 0; k < NST; k++) begin
                r_pl[k] <= n_pl[k];
            end
        end
    end

    assign o_valid        = r_vld[NST-1];
    assign o_inside_res   = r_pl[NST-1].in_lens;
    assign o_source_index = r_pl[NST-1].index;
    assign o_span_width   = r_pl[NST-1].width;
    assign o_span_start   = r_pl[NST-1].start;
    assign o_config_error = r_pl[NST-1].err;

    // an outside pixel never points into the captured square
    `LBRC_ASSERT_IMP(a_outside_zero, i_clk, i_rst_n, o_valid && !o_inside_res, o_source_index == '0)
    // an inside pixel sits on a non-empty row of a valid lens
    `LBRC_ASSERT_IMP(a_inside_span, i_clk, i_rst_n, o_valid && o_inside_res, o_span_width != '0 && !o_config_error)
    // span width is always even
    `LBRC_ASSERT_IMP(a_width_even, i_clk, i_rst_n, o_valid, !o_span_width[0])
    // no beat enters while the output beat is held
    `LBRC_ASSERT(a_stall_blocks, i_clk, i_rst_n, !(o_valid && !i_ready && o_ready))
endmodule
